>>> design/depth_pixel_plane_band_filter_core_defines.svh
// Assertion macros for the depth plane band filter RTL
`ifndef DEPTH_PIXEL_PLANE_BAND_FILTER_CORE_DEFINES_SVH
`define DEPTH_PIXEL_PLANE_BAND_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define DPPBF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define DPPBF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/dppbf_pkg.sv
// Shared widths, register map, stage map and config type of the depth plane band filter
package dppbf_pkg;

    localparam int PIX_W    = 12;
    localparam int DEPTH_W  = 24;
    localparam int CTR_W    = 16;
    localparam int INV_W    = 24;
    localparam int COEF_W   = 18;
    localparam int COORD_W  = 32;
    localparam int TOL_W    = 31;

    localparam int OFS_W    = PIX_W + 5;
    localparam int MAG_W    = OFS_W - 1;
    localparam int ZI_W     = DEPTH_W + INV_W;
    localparam int HALF_W   = ZI_W / 2;
    localparam int PP_W     = MAG_W + HALF_W;
    localparam int PROD_W   = MAG_W + ZI_W;
    localparam int FRAC_SH  = 28;
    localparam int RND_W    = PROD_W - FRAC_SH;
    localparam int PA_W     = COEF_W + COORD_W;
    localparam int PC_W     = COEF_W + DEPTH_W + 1;
    localparam int PLANE_SH = 16;
    localparam int DIST_W   = 52;

    localparam logic [DEPTH_W-1:0] INVALID_DEPTH = DEPTH_W'(10240000);
    localparam logic [PROD_W-1:0]  ROUND_HALF    = PROD_W'(64'h0000_0000_0800_0000);
    localparam logic [RND_W-1:0]   POS_LIM       = RND_W'(64'h0000_0000_7FFF_FFFF);
    localparam logic [RND_W-1:0]   NEG_LIM       = RND_W'(64'h0000_0000_8000_0000);
    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_POINT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_A        = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_B        = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_C        = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_OFFSET    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_TOLERANCE  = 4'd7;

    // Pipeline stage map
    localparam int ST_OFS     = 0;
    localparam int ST_PP      = 1;
    localparam int ST_RND     = 2;
    localparam int ST_SAT     = 3;
    localparam int ST_MUL     = 4;
    localparam int ST_SUM     = 5;
    localparam int ST_OUT     = 6;
    localparam int NUM_STAGES = 7;

    typedef logic [NUM_STAGES-1:0] t_stage_en;

    typedef struct packed {
        logic [CTR_W-1:0]          cx;
        logic [CTR_W-1:0]          cy;
        logic [INV_W-1:0]          inv_focal_x;
        logic [INV_W-1:0]          inv_focal_y;
        logic signed [COEF_W-1:0]  normal_a;
        logic signed [COEF_W-1:0]  normal_b;
        logic signed [COEF_W-1:0]  normal_c;
        logic signed [COORD_W-1:0] plane_offset;
        logic [TOL_W-1:0]          band_tolerance;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        cx:             16'h1400,
        cy:             16'h0F00,
        inv_focal_x:    24'd31957,
        inv_focal_y:    24'd31957,
        normal_a:       18'sd0,
        normal_b:       18'sd65536,
        normal_c:       18'sd0,
        plane_offset:   32'sd0,
        band_tolerance: 31'd102
    };

endpackage

>>> design/dppbf_cfg.sv
// Configuration register file of the depth plane band filter
module dppbf_cfg
    import dppbf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PRINCIPAL_POINT: begin
                    r_cfg.cx <= i_cfg_data[CTR_W-1:0];
                    r_cfg.cy <= i_cfg_data[2*CTR_W-1:CTR_W];
                end
                REG_INV_FOCAL_X:    r_cfg.inv_focal_x    <= i_cfg_data[INV_W-1:0];
                REG_INV_FOCAL_Y:    r_cfg.inv_focal_y    <= i_cfg_data[INV_W-1:0];
                REG_NORMAL_A:       r_cfg.normal_a       <= $signed(i_cfg_data[COEF_W-1:0]);
                REG_NORMAL_B:       r_cfg.normal_b       <= $signed(i_cfg_data[COEF_W-1:0]);
                REG_NORMAL_C:       r_cfg.normal_c       <= $signed(i_cfg_data[COEF_W-1:0]);
                REG_PLANE_OFFSET:   r_cfg.plane_offset   <= $signed(i_cfg_data[COORD_W-1:0]);
                REG_BAND_TOLERANCE: r_cfg.band_tolerance <= i_cfg_data[TOL_W-1:0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

endmodule

>>> design/dppbf_bproj.sv
// Four-stage pinhole back-projection of one pixel axis with rounding and saturation
module dppbf_bproj
    import dppbf_pkg::*;
(
    input  logic                       i_clk,
    input  t_stage_en                  i_adv,
    input  logic [PIX_W-1:0]           i_pixel,
    input  logic [CTR_W-1:0]           i_center,
    input  logic [DEPTH_W-1:0]         i_depth,
    input  logic [INV_W-1:0]           i_inv,
    output logic signed [COORD_W-1:0]  o_coord
);

    logic signed [OFS_W-1:0]   ofs;
    logic [MAG_W-1:0]          n_mag;
    logic [PROD_W-1:0]         n_sum;
    logic signed [RND_W:0]     n_sgn;
    logic signed [COORD_W-1:0] n_coord;

    logic                      r1_neg;
    logic [MAG_W-1:0]          r1_mag;
    logic [ZI_W-1:0]           r1_zi;
    logic                      r2_neg;
    logic [PP_W-1:0]           r2_lo;
    logic [PP_W-1:0]           r2_hi;
    logic                      r3_neg;
    logic [RND_W-1:0]          r3_mag;
    logic signed [COORD_W-1:0] r4_coord;

    // Q.4 pixel offset from the principal point, split into sign and magnitude
    always_comb begin
        ofs   = $signed({1'b0, i_pixel, 4'b0000}) - $signed({1'b0, i_center});
        n_mag = ofs[OFS_W-1] ? MAG_W'(-ofs) : ofs[MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[ST_OFS]) begin
            r1_neg <= ofs[OFS_W-1];
            r1_mag <= n_mag;
            r1_zi  <= i_depth * i_inv;
        end
    end

    // split the wide product into two partial products
    always_ff @(posedge i_clk) begin
        if (i_adv[ST_PP]) begin
            r2_neg <= r1_neg;
            r2_lo  <= r1_mag * r1_zi[HALF_W-1:0];
            r2_hi  <= r1_mag * r1_zi[ZI_W-1:HALF_W];
        end
    end

    // Q.38 to Q.10, round half away from zero on the magnitude
    always_comb begin
        n_sum = {r2_hi, {HALF_W{1'b0}}} + {{(PROD_W-PP_W){1'b0}}, r2_lo} + ROUND_HALF;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[ST_RND]) begin
            r3_neg <= r2_neg;
            r3_mag <= n_sum[PROD_W-1:FRAC_SH];
        end
    end

    always_comb begin
        n_sgn = r3_neg ? -$signed({1'b0, r3_mag}) : $signed({1'b0, r3_mag});
        priority if (!r3_neg && r3_mag > POS_LIM) begin
            n_coord = COORD_MAX;
        end else if (r3_neg && r3_mag > NEG_LIM) begin
            n_coord = COORD_MIN;
        end else begin
            n_coord = n_sgn[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[ST_SAT]) begin
            r4_coord <= n_coord;
        end
    end

    assign o_coord = r4_coord;

endmodule

>>> design/dppbf_plane.sv
// Three-stage plane distance test and output register of the depth plane band filter
module dppbf_plane
    import dppbf_pkg::*;
(
    input  logic                       i_clk,
    input  t_stage_en                  i_adv,
    input  t_cfg                       i_cfg,
    input  logic signed [COORD_W-1:0]  i_x,
    input  logic signed [COORD_W-1:0]  i_y,
    input  logic [DEPTH_W-1:0]         i_z,
    output logic                       o_pass,
    output logic signed [COORD_W-1:0]  o_point_x,
    output logic signed [COORD_W-1:0]  o_point_y,
    output logic [DEPTH_W-1:0]         o_point_z
);

    logic signed [PA_W-1:0]    r5_pa;
    logic signed [PA_W-1:0]    r5_pb;
    logic signed [PC_W-1:0]    r5_pc;
    logic signed [COORD_W-1:0] r5_x;
    logic signed [COORD_W-1:0] r5_y;
    logic [DEPTH_W-1:0]        r5_z;
    logic signed [DIST_W-1:0]  r6_dist;
    logic signed [COORD_W-1:0] r6_x;
    logic signed [COORD_W-1:0] r6_y;
    logic [DEPTH_W-1:0]        r6_z;
    logic signed [DIST_W-1:0]  n_dist;
    logic signed [DIST_W-1:0]  lim;

    always_ff @(posedge i_clk) begin
        if (i_adv[ST_MUL]) begin
            r5_pa <= i_cfg.normal_a * i_x;
            r5_pb <= i_cfg.normal_b * i_y;
            r5_pc <= i_cfg.normal_c * $signed({1'b0, i_z});
            r5_x  <= i_x;
            r5_y  <= i_y;
            r5_z  <= i_z;
        end
    end

    // exact Q.26 signed distance
    always_comb begin
        n_dist = DIST_W'(r5_pa) + DIST_W'(r5_pb) + DIST_W'(r5_pc)
               + DIST_W'($signed({i_cfg.plane_offset, {PLANE_SH{1'b0}}}));
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[ST_SUM]) begin
            r6_dist <= n_dist;
            r6_x    <= r5_x;
            r6_y    <= r5_y;
            r6_z    <= r5_z;
        end
    end

    // |dist| < tol, checked as -lim < dist < lim
    always_comb begin
        lim    = $signed({{(DIST_W-TOL_W-PLANE_SH){1'b0}}, i_cfg.band_tolerance,
                          {PLANE_SH{1'b0}}});
        o_pass = (r6_dist < lim) && (r6_dist > -lim);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[ST_OUT]) begin
            o_point_x <= r6_x;
            o_point_y <= r6_y;
            o_point_z <= r6_z;
        end
    end

endmodule

>>> design/depth_pixel_plane_band_filter_core.sv
// Top level of the depth plane band filter: config, two back-projection lanes, plane test
// Takes one depth word per clock while o_in_ready is high and delivers its back-projected point
// if the depth is valid and the point lies strictly inside the configured band around the plane.
// The seven register stages are offset and z/f product, partial products, rounding, saturation,
// plane products, distance sum, and the output register; each stage holds a valid bit and
// advances whenever it is empty or the stage after it advances, so a stall at the output fills
// bubbles before o_in_ready drops, and a new word is taken every cycle while words flow. Dropped
// words leave a bubble and yield no output word. Writes to indexes past the register list are
// ignored. Configuration must be written only while no word is in flight; not enforced here.
`include "depth_pixel_plane_band_filter_core_defines.svh"

module depth_pixel_plane_band_filter_core
    import dppbf_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [PIX_W-1:0]           i_pixel_row,
    input  logic [PIX_W-1:0]           i_pixel_col,
    input  logic [DEPTH_W-1:0]         i_depth_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [COORD_W-1:0]  o_point_x,
    output logic signed [COORD_W-1:0]  o_point_y,
    output logic [DEPTH_W-1:0]         o_point_z,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    t_cfg                      cfg;
    t_stage_en                 adv;
    t_stage_en                 n_vld;
    t_stage_en                 r_vld;
    logic                      depth_ok;
    logic                      pass;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic [DEPTH_W-1:0]        r_z [ST_OFS:ST_SAT];

    dppbf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    dppbf_bproj u_bproj_x (
        .i_clk    (i_clk),
        .i_adv    (adv),
        .i_pixel  (i_pixel_col),
        .i_center (cfg.cx),
        .i_depth  (i_depth_value),
        .i_inv    (cfg.inv_focal_x),
        .o_coord  (coord_x)
    );

    dppbf_bproj u_bproj_y (
        .i_clk    (i_clk),
        .i_adv    (adv),
        .i_pixel  (i_pixel_row),
        .i_center (cfg.cy),
        .i_depth  (i_depth_value),
        .i_inv    (cfg.inv_focal_y),
        .o_coord  (coord_y)
    );

    dppbf_plane u_plane (
        .i_clk     (i_clk),
        .i_adv     (adv),
        .i_cfg     (cfg),
        .i_x       (coord_x),
        .i_y       (coord_y),
        .i_z       (r_z[ST_SAT]),
        .o_pass    (pass),
        .o_point_x (o_point_x),
        .o_point_y (o_point_y),
        .o_point_z (o_point_z)
    );

    assign depth_ok = (i_depth_value != '0) && (i_depth_value != INVALID_DEPTH);

    // a stage advances when empty or when the next one advances
    always_comb begin
        adv[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    always_comb begin
        n_vld         = r_vld << 1;
        n_vld[ST_OFS] = i_in_valid && depth_ok;
        n_vld[ST_OUT] = r_vld[ST_SUM] && pass;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // carry depth alongside the back-projection lanes
    always_ff @(posedge i_clk) begin
        if (adv[ST_OFS]) begin
            r_z[ST_OFS] <= i_depth_value;
        end
        for (int k = ST_OFS + 1; k <= ST_SAT; k++) begin
            if (adv[k]) begin
                r_z[k] <= r_z[k-1];
            end
        end
    end

    assign o_in_ready  = adv[ST_OFS];
    assign o_out_valid = r_vld[ST_OUT];

    `DPPBF_ASSERT_NEXT(a_drop_invalid_depth, i_in_valid && o_in_ready && !depth_ok, !r_vld[ST_OFS], "invalid depth word entered the pipeline")
    `DPPBF_ASSERT_NEXT(a_bubble_reaches_out, !r_vld[ST_SUM] && adv[ST_OUT], !o_out_valid, "output word appeared from an empty stage")
    `DPPBF_ASSERT_NOW(a_stall_only_when_full, !o_in_ready, &r_vld, "input stalled while the pipeline holds a bubble")

endmodule

>>> verif/dppbf_point_checker.sv
// Point checker for the depth plane band filter: predicts each emitted point and compares it
module dppbf_point_checker
    import dppbf_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [PIX_W-1:0]          i_pixel_row,
    input  logic [PIX_W-1:0]          i_pixel_col,
    input  logic [DEPTH_W-1:0]        i_depth_value,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    input  logic [DEPTH_W-1:0]        i_point_z,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    output int                        o_mismatches,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [65:0] HALF_LSB = 66'd1 << 27;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [DEPTH_W-1:0]        z;
    } t_point;

    t_cfg   regs = CFG_RESET;
    t_point points_due[$];
    int     mismatches = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    // Q.4 pixel offset times Q.10 depth times Q0.24 reciprocal, rounded to Q.10, saturated
    function automatic logic signed [COORD_W-1:0] project_axis(input longint ofs,
                                                               input logic [DEPTH_W-1:0] z,
                                                               input logic [INV_W-1:0] inv);
        logic [65:0] mag;
        logic [65:0] prod;
        logic [65:0] r;
        mag  = (ofs < 0) ? 66'(-ofs) : 66'(ofs);
        prod = mag * 66'(z) * 66'(inv);
        r    = (prod + HALF_LSB) >> FRAC_SH;
        if (ofs < 0)
            return (r > 66'h8000_0000) ? COORD_MIN : COORD_W'(-r);
        return (r > 66'h7FFF_FFFF) ? COORD_MAX : COORD_W'(r);
    endfunction

    function automatic bit inside_band(input logic signed [COORD_W-1:0] x,
                                       input logic signed [COORD_W-1:0] y,
                                       input logic [DEPTH_W-1:0] z);
        longint plane_gap;
        longint lim;
        plane_gap = longint'($signed(regs.normal_a)) * longint'(x)
                  + longint'($signed(regs.normal_b)) * longint'(y)
                  + longint'($signed(regs.normal_c)) * longint'(z)
                  + longint'($signed(regs.plane_offset)) * 65536;
        if (plane_gap < 0)
            plane_gap = -plane_gap;
        lim = longint'(regs.band_tolerance) * 65536;
        return plane_gap < lim;
    endfunction

    always @(posedge i_clk) begin : watch
        t_point got;
        t_point want;
        t_point due;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        if (!i_rst_n) begin
            regs = CFG_RESET;
            points_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_PRINCIPAL_POINT: begin
                        regs.cx = i_cfg_data[15:0];
                        regs.cy = i_cfg_data[31:16];
                    end
                    REG_INV_FOCAL_X:    regs.inv_focal_x    = i_cfg_data[INV_W-1:0];
                    REG_INV_FOCAL_Y:    regs.inv_focal_y    = i_cfg_data[INV_W-1:0];
                    REG_NORMAL_A:       regs.normal_a       = i_cfg_data[COEF_W-1:0];
                    REG_NORMAL_B:       regs.normal_b       = i_cfg_data[COEF_W-1:0];
                    REG_NORMAL_C:       regs.normal_c       = i_cfg_data[COEF_W-1:0];
                    REG_PLANE_OFFSET:   regs.plane_offset   = i_cfg_data;
                    REG_BAND_TOLERANCE: regs.band_tolerance = i_cfg_data[TOL_W-1:0];
                    default: ;
                endcase
            end

            // drop zero and invalid-marker depths before projecting
            if (i_in_valid && i_in_ready && i_depth_value != '0
                    && i_depth_value != INVALID_DEPTH) begin
                px = project_axis(longint'(i_pixel_col) * 16 - longint'(regs.cx),
                                  i_depth_value, regs.inv_focal_x);
                py = project_axis(longint'(i_pixel_row) * 16 - longint'(regs.cy),
                                  i_depth_value, regs.inv_focal_y);
                if (inside_band(px, py, i_depth_value)) begin
                    due = '{px, py, i_depth_value};
                    points_due.insert(points_due.size(), due);
                end
            end

            if (i_out_valid && i_out_ready) begin
                got = '{i_point_x, i_point_y, i_point_z};
                if (points_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected point: expected none, got x %0d y %0d z %0d",
                             $time, got.x, got.y, got.z);
                end else begin
                    want = points_due.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (got.x != want.x)
                            $display("%0t: point_x expected %0d, got %0d",
                                     $time, want.x, got.x);
                        if (got.y != want.y)
                            $display("%0t: point_y expected %0d, got %0d",
                                     $time, want.y, got.y);
                        if (got.z != want.z)
                            $display("%0t: point_z expected %0d, got %0d",
                                     $time, want.z, got.z);
                    end
                end
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= points_due.size();
    end

endmodule

>>> verif/depth_pixel_plane_band_filter_core_tb.sv
// Stimulus and verdict for the depth plane band filter core
module depth_pixel_plane_band_filter_core_tb
    import dppbf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE      = 16;
    localparam int LONG_HOLD   = 60;
    localparam int HOLD_WORDS  = 40;
    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 80;

    typedef enum int {SET_GROUND, SET_WIDE, SET_ANY} t_setting;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [PIX_W-1:0]          pixel_row;
    logic [PIX_W-1:0]          pixel_col;
    logic [DEPTH_W-1:0]        depth_value;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [DEPTH_W-1:0]        point_z;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;

    int mismatches;
    int pending;
    bit tx_gaps  = 1'b1;
    bit rx_gaps  = 1'b1;
    bit hold_req = 1'b0;

    depth_pixel_plane_band_filter_core dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_pixel_row   (pixel_row),
        .i_pixel_col   (pixel_col),
        .i_depth_value (depth_value),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_point_x     (point_x),
        .o_point_y     (point_y),
        .o_point_z     (point_z),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    dppbf_point_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_pixel_row   (pixel_row),
        .i_pixel_col   (pixel_col),
        .i_depth_value (depth_value),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_point_x     (point_x),
        .i_point_y     (point_y),
        .i_point_z     (point_z),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                out_ready <= 1'b1;
            end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("** depth_pixel_plane_band_filter_core: FAILED **");
        $finish;
    end

    task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] c,
                              input logic [DEPTH_W-1:0] d);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel_row   <= r;
        pixel_col   <= c;
        depth_value <= d;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_random_pixel();
        logic [PIX_W-1:0]   r;
        logic [PIX_W-1:0]   c;
        logic [DEPTH_W-1:0] d;
        case ($urandom_range(0, 9))
            0: begin
                r = PIX_W'($urandom);
                c = PIX_W'($urandom);
                d = DEPTH_W'($urandom);
            end
            1: begin
                r = PIX_W'($urandom);
                c = PIX_W'($urandom);
                d = $urandom_range(0, 1) ? '0 : INVALID_DEPTH;
            end
            default: begin
                // camera-like frame: VGA pixel, depth up to about 12 m
                r = PIX_W'($urandom_range(0, 479));
                c = PIX_W'($urandom_range(0, 639));
                d = DEPTH_W'($urandom_range(256, 12288));
            end
        endcase
        send_pixel(r, c, d);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write of a batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Wait until every expected point is out, then let dropped words clear the pipe
    task automatic drain();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_edge(input logic [31:0] lo, input logic [31:0] hi);
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return hi;
            default: return $urandom;
        endcase
    endfunction

    task automatic load_setting(input t_setting kind);
        logic [31:0] pp, ifx, ify, na, nb, nc, ofs, tol;
        case (kind)
            SET_GROUND: begin
                pp  = {16'($urandom_range(0, 7680)), 16'($urandom_range(0, 10240))};
                ifx = $urandom_range(16000, 64000);
                ify = $urandom_range(16000, 64000);
                na  = 32'($urandom_range(0, 16384)) - 32'd8192;
                nb  = ($urandom_range(0, 1) ? 32'd65536 : 32'(-65536))
                    + 32'($urandom_range(0, 4096)) - 32'd2048;
                nc  = 32'($urandom_range(0, 8192)) - 32'd4096;
                ofs = 32'($urandom_range(0, 4096)) - 32'd2048;
                tol = $urandom_range(50, 4096);
            end
            SET_WIDE: begin
                pp  = $urandom;
                ifx = $urandom;
                ify = $urandom;
                na  = $urandom;
                nb  = $urandom;
                nc  = $urandom;
                ofs = $urandom;
                tol = {2'b01, 30'($urandom)};
            end
            default: begin
                pp  = pick_edge(32'h0, 32'hFFFF_FFFF);
                ifx = pick_edge(32'h0, 32'h00FF_FFFF);
                ify = pick_edge(32'h0, 32'h00FF_FFFF);
                na  = pick_edge(32'(-131072), 32'd131071);
                nb  = pick_edge(32'(-131072), 32'd131071);
                nc  = pick_edge(32'(-131072), 32'd131071);
                ofs = pick_edge(32'h8000_0000, 32'h7FFF_FFFF);
                tol = pick_edge(32'h0, 32'h7FFF_FFFF);
            end
        endcase
        write_reg(REG_PRINCIPAL_POINT, pp);
        write_reg(REG_INV_FOCAL_X, ifx);
        write_reg(REG_INV_FOCAL_Y, ify);
        write_reg(REG_NORMAL_A, na);
        write_reg(REG_NORMAL_B, nb);
        write_reg(REG_NORMAL_C, nc);
        write_reg(REG_PLANE_OFFSET, ofs);
        write_reg(REG_BAND_TOLERANCE, tol);
        // unmapped index: must leave every register alone
        write_reg(CFG_IDX_W'(REG_BAND_TOLERANCE + 1 + $urandom_range(0, 7)), $urandom);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        in_valid    <= 1'b0;
        pixel_row   <= '0;
        pixel_col   <= '0;
        depth_value <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        rst_n       <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: level ground plane, 0.1 m band around y = 0
        send_pixel(12'd240, 12'd0, 24'd1);
        send_pixel(12'd240, 12'hFFF, 24'hFF_FFFF);
        send_pixel(12'd240, 12'd320, 24'd10240);
        send_pixel(12'd0, 12'd0, 24'd0);
        send_pixel(12'd240, 12'd100, INVALID_DEPTH);
        send_pixel(12'd240, 12'd100, INVALID_DEPTH - 1);
        send_pixel(12'd240, 12'd100, INVALID_DEPTH + 1);
        send_pixel(12'hFFF, 12'hFFF, 24'hFF_FFFF);
        send_pixel(12'd0, 12'd0, 24'd1024);
        send_pixel(12'd241, 12'd320, 24'd1024);
        send_pixel(12'd250, 12'd320, 24'd10240);
        send_pixel(12'd245, 12'd320, 24'd10240);
        in_valid <= 1'b0;
        drain();

        // Flat plane at distance equal to the band: everything falls out
        write_reg(REG_PRINCIPAL_POINT, 32'hFFFF_FFFF);
        write_reg(REG_INV_FOCAL_X, 32'h00FF_FFFF);
        write_reg(REG_INV_FOCAL_Y, 32'h0);
        write_reg(REG_NORMAL_A, 32'h0);
        write_reg(REG_NORMAL_B, 32'h0);
        write_reg(REG_NORMAL_C, 32'h0);
        write_reg(REG_PLANE_OFFSET, 32'(-5));
        write_reg(REG_BAND_TOLERANCE, 32'd5);
        cfg_valid <= 1'b0;
        send_pixel(12'd100, 12'd100, 24'd1024);
        send_pixel(12'hFFF, 12'd0, 24'hFF_FFFF);
        in_valid <= 1'b0;
        drain();

        // One step wider: all pass; far-off principal point saturates x negative
        write_reg(REG_BAND_TOLERANCE, 32'd6);
        cfg_valid <= 1'b0;
        send_pixel(12'd0, 12'd0, 24'hFF_FFFF);
        send_pixel(12'hFFF, 12'hFFF, 24'hFF_FFFF);
        in_valid <= 1'b0;
        drain();

        write_reg(REG_PRINCIPAL_POINT, 32'h0);
        cfg_valid <= 1'b0;
        send_pixel(12'hFFF, 12'hFFF, 24'hFF_FFFF);
        send_pixel(12'd0, 12'd0, 24'd1);
        in_valid <= 1'b0;
        drain();

        // Coefficient and offset extremes
        write_reg(REG_NORMAL_A, 32'(-131072));
        write_reg(REG_NORMAL_B, 32'd131071);
        write_reg(REG_NORMAL_C, 32'(-131072));
        write_reg(REG_PLANE_OFFSET, 32'h7FFF_FFFF);
        write_reg(REG_BAND_TOLERANCE, 32'h7FFF_FFFF);
        write_reg(CFG_IDX_W'(REG_BAND_TOLERANCE + 1), 32'h0);
        cfg_valid <= 1'b0;
        send_pixel(12'd5, 12'd10, 24'd1024);
        send_pixel(12'd5, 12'd10, 24'hFF_FFFF);
        in_valid <= 1'b0;
        drain();

        // Everything passes; hold the result side so the pipe fills and backs up
        write_reg(REG_PRINCIPAL_POINT, 32'h0F00_1400);
        write_reg(REG_INV_FOCAL_X, 32'd31957);
        write_reg(REG_INV_FOCAL_Y, 32'd31957);
        write_reg(REG_NORMAL_A, 32'h0);
        write_reg(REG_NORMAL_B, 32'h0);
        write_reg(REG_NORMAL_C, 32'h0);
        write_reg(REG_PLANE_OFFSET, 32'h0);
        write_reg(REG_BAND_TOLERANCE, 32'h7FFF_FFFF);
        cfg_valid <= 1'b0;
        tx_gaps  = 1'b0;
        hold_req = 1'b1;
        repeat (HOLD_WORDS)
            send_pixel(PIX_W'($urandom), PIX_W'($urandom),
                       DEPTH_W'($urandom_range(1, 10239999)));
        in_valid <= 1'b0;
        tx_gaps = 1'b1;
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == PHASES - 1) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            load_setting(t_setting'(ph % 3));
            repeat (PHASE_WORDS) send_random_pixel();
            in_valid <= 1'b0;
            drain();
        end

        if (mismatches == 0 && pending == 0)
            $display("** depth_pixel_plane_band_filter_core: PASSED **");
        else
            $display("** depth_pixel_plane_band_filter_core: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/dppbf_pkg.sv
design/dppbf_cfg.sv
design/dppbf_bproj.sv
design/dppbf_plane.sv
design/depth_pixel_plane_band_filter_core.sv
verif/dppbf_point_checker.sv
verif/depth_pixel_plane_band_filter_core_tb.sv
